FILE: design/stream_byte_reassembler_unit_defines.svh
// Assertion macros shared by the stream byte reassembler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STREAM_BYTE_REASSEMBLER_UNIT_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SBR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("sbr assertion failed");
`define SBR_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("sbr forbidden condition");
`else
`define SBR_ASSERT(lbl, clk, rstn, prop)
`define SBR_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: design/sbr_pkg.sv
// Shared types and codes for the stream byte reassembler.
// No dependencies.
`default_nettype none
package sbr_pkg;

  localparam int unsigned IdxW  = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PendW = 11;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_MARK  = 2'd1;
  localparam logic [1:0] MODE_PULL  = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } sbr_slot_t;

  typedef struct packed {
    logic valid_we;
    logic valid_bit;
    logic byte_we;
  } sbr_wr_t;

endpackage
`default_nettype wire

FILE: design/sbr_window.sv
// Window slot store: byte memory and valid-bit memory, one write and one
// registered read per cycle, with bypass of a same-cycle write. Uses sbr_pkg.
`default_nettype none
module sbr_window import sbr_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output sbr_slot_t             rd_slot_o,
  input  wire sbr_wr_t          wr_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [ByteW-1:0] wr_data_i
);

  logic             valid_mem [Depth];
  logic [ByteW-1:0] byte_mem  [Depth];

  logic             rd_valid_q;
  logic [ByteW-1:0] rd_byte_q;
  logic             fwd_hit_q;
  sbr_slot_t        fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.valid_we) begin
      valid_mem[wr_addr_i] <= wr_i.valid_bit;
    end
    if (wr_i.byte_we) begin
      byte_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_valid_q <= valid_mem[rd_addr_i];
      rd_byte_q  <= byte_mem[rd_addr_i];
      fwd_q      <= '{valid: wr_i.valid_bit, data: wr_data_i};
    end
  end

  // bypass: the write landing at the read edge is not yet in the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_i.valid_we && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_slot_o = fwd_hit_q ? fwd_q : '{valid: rd_valid_q, data: rd_byte_q};

endmodule
`default_nettype wire

FILE: design/stream_byte_reassembler_unit.sv
// Stream byte reassembler top level: window control, pull head, counters.
// Depends on sbr_pkg, sbr_window and stream_byte_reassembler_unit_defines.svh.
//
//  channel | direction | ports                                   | handshake
//  in      | sink      | mode_i, stream_index_i, data_byte_i     | in_valid_i / in_ready_o
//  out     | source    | byte_valid_o, out_byte_o,               | out_valid_o / out_ready_i
//          |           | stream_closed_o, pending_count_o        |
//
// One item per cycle while the output does not stall; each item gives one result through
// the staged item and result registers. The slot memories are read at the input transfer
// and written when the staged item moves on; a clearing pass over all WINDOW_BYTES slots
// after reset zeroes the valid bits; in_ready_o stays low until it finishes.
// A stalled output holds the staged item and the input in turn.
`default_nettype none
`include "stream_byte_reassembler_unit_defines.svh"
module stream_byte_reassembler_unit import sbr_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [IdxW-1:0]  stream_index_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  byte_valid_o,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  stream_closed_o,
  output logic [PendW-1:0]      pending_count_o
);

  localparam int unsigned AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int unsigned CW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [SW-1:0]   WRAP   = SW'(WINDOW_BYTES);
  localparam logic [AW-1:0]   LAST   = AW'(WINDOW_BYTES - 1);
  localparam logic [IdxW-1:0] WIN64  = IdxW'(WINDOW_BYTES);
  localparam logic [CW-1:0]   WINCNT = CW'(WINDOW_BYTES);

  // control state
  logic            clr_q, clr_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            s1_v_q, s1_v_d;
  logic            out_v_q, out_v_d;
  logic [IdxW-1:0] next_q, next_d;
  logic [AW-1:0]   head_q, head_d;
  logic            end_seen_q, end_seen_d;
  logic [IdxW-1:0] end_index_q, end_index_d;
  logic [CW-1:0]   pending_q, pending_d;

  // staged item
  logic [1:0]       s1_mode_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [ByteW-1:0] s1_byte_q;
  logic [AW-1:0]    s1_slot_q;

  // result register
  logic             res_got_q;
  logic [ByteW-1:0] res_byte_q;
  logic             res_closed_q;
  logic [PendW-1:0] res_pend_q;

  logic             accept, s2_fire;
  logic [IdxW-1:0]  diff_acc, diff2, next_inc;
  logic [SW-1:0]    sum0, sum1, sum2;
  logic [AW-1:0]    store_slot, rd_addr, wr_addr;
  sbr_slot_t        slot;
  sbr_wr_t          wr;
  logic             is_store, is_mark, is_pull, in_win, store_ok, got, closed;

  assign s2_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_v_q || s2_fire);
  assign accept     = in_valid_i && in_ready_o;

  // slot of a store, relative to the current head
  always_comb begin
    diff_acc   = stream_index_i - next_q;
    sum0       = {2'b00, head_q} + {1'b0, diff_acc[AW:0]};
    sum1       = (sum0 >= WRAP) ? sum0 - WRAP : sum0;
    sum2       = (sum1 >= WRAP) ? sum1 - WRAP : sum1;
    store_slot = sum2[AW-1:0];
    rd_addr    = (mode_i == MODE_PULL) ? head_d : store_slot;
  end

  always_comb begin
    is_store = (s1_mode_q == MODE_STORE);
    is_mark  = (s1_mode_q == MODE_MARK);
    is_pull  = (s1_mode_q == MODE_PULL);
    diff2    = s1_idx_q - next_q;
    in_win   = (s1_idx_q >= next_q) && (diff2 < WIN64);
    store_ok = s2_fire && is_store && in_win;
    got      = s2_fire && is_pull && slot.valid;
    next_inc = next_q + 1'b1;

    next_d      = got ? next_inc : next_q;
    head_d      = got ? ((head_q == LAST) ? '0 : head_q + 1'b1) : head_q;
    end_seen_d  = end_seen_q;
    end_index_d = end_index_q;
    if (s2_fire && is_mark) begin
      end_seen_d  = 1'b1;
      end_index_d = s1_idx_q;
    end
    pending_d = pending_q;
    if (store_ok && !slot.valid) begin
      pending_d = pending_q + 1'b1;
    end else if (got) begin
      pending_d = pending_q - 1'b1;
    end

    if (s2_fire && is_mark) begin
      closed = (next_q >= s1_idx_q);
    end else if (got) begin
      closed = end_seen_q && (next_inc >= end_index_q);
    end else begin
      closed = end_seen_q && (next_q >= end_index_q);
    end

    wr.valid_we  = clr_q || store_ok || got;
    wr.valid_bit = store_ok;
    wr.byte_we   = store_ok;
    wr_addr      = clr_q ? clr_cnt_q : s1_slot_q;
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST) begin
        clr_d = 1'b0;
      end
    end
    s1_v_d = accept ? 1'b1 : (s2_fire ? 1'b0 : s1_v_q);
    out_v_d = s2_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
  end

  sbr_window #(
    .Depth (WINDOW_BYTES),
    .AddrW (AW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_slot_o (slot),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (s1_byte_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      next_q      <= '0;
      head_q      <= '0;
      end_seen_q  <= 1'b0;
      end_index_q <= '0;
      pending_q   <= '0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_v_q      <= s1_v_d;
      out_v_q     <= out_v_d;
      next_q      <= next_d;
      head_q      <= head_d;
      end_seen_q  <= end_seen_d;
      end_index_q <= end_index_d;
      pending_q   <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= mode_i;
      s1_idx_q  <= stream_index_i;
      s1_byte_q <= data_byte_i;
      s1_slot_q <= rd_addr;
    end
    if (s2_fire) begin
      res_got_q    <= got;
      res_byte_q   <= got ? slot.data : '0;
      res_closed_q <= closed;
      res_pend_q   <= PendW'(pending_d);
    end
  end

  assign out_valid_o     = out_v_q;
  assign byte_valid_o    = res_got_q;
  assign out_byte_o      = res_byte_q;
  assign stream_closed_o = res_closed_q;
  assign pending_count_o = res_pend_q;

  `SBR_ASSERT(a_pend_bound, clk_i, rst_ni, pending_q <= WINCNT)
  `SBR_ASSERT(a_head_bound, clk_i, rst_ni, head_q <= LAST)
  `SBR_ASSERT(a_pull_count, clk_i, rst_ni, got |=> pending_q == $past(pending_q) - 1'b1)
  `SBR_ASSERT(a_next_hold, clk_i, rst_ni, !got |=> next_q == $past(next_q))
  `SBR_NEVER(a_no_item_clr, clk_i, rst_ni, clr_q && (s1_v_q || out_v_q))

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for stream_byte_reassembler_unit: a table of directed rows, a full window fill and
// random traffic with idle cycles and stalls on both channels, checked against a built-in predictor.
// Depends on sbr_pkg and the reassembler RTL.
`timescale 1ns / 100ps
module testbench import sbr_pkg::*; ();

  localparam int unsigned WIN = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MIXED_ITEMS = 270;
  localparam int unsigned HOLD_AFTER = 700;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0] IDX_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic             got;
    logic [ByteW-1:0] val;
    logic             closed;
    logic [PendW-1:0] pend;
  } reasm_result_t;

  typedef struct packed {
    logic [1:0]       md;
    logic [IdxW-1:0]  ix;
    logic [ByteW-1:0] dat;
    logic             typed;
    reasm_result_t    want;
  } stim_row_t;

  localparam reasm_result_t NO_RES = '0;

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{MODE_PULL,   64'd0,    8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd0}},
    '{MODE_UNUSED, IDX_MAX,  8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd0}},
    '{MODE_STORE,  64'd0,    8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd1}},
    '{MODE_STORE,  64'd0,    8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd1}},
    '{MODE_STORE,  64'd1023, 8'hA5, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd2}},
    '{MODE_STORE,  64'd1024, 8'h5A, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd2}},
    '{MODE_STORE,  IDX_MAX,  8'h11, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd2}},
    '{MODE_MARK,   64'd2,    8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd2}},
    '{MODE_PULL,   64'd0,    8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 11'd1}},
    '{MODE_STORE,  64'd0,    8'h77, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd1}},
    '{MODE_MARK,   64'd0,    8'h00, 1'b1, '{1'b0, 8'h00, 1'b1, 11'd1}},
    '{MODE_MARK,   IDX_MAX,  8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd1}},
    '{MODE_STORE,  64'd1,    8'h5A, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd2}},
    '{MODE_PULL,   64'd0,    8'h00, 1'b1, '{1'b1, 8'h5A, 1'b0, 11'd1}},
    '{MODE_PULL,   64'd0,    8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 11'd1}},
    '{MODE_STORE,  64'd1024, 8'h3C, 1'b0, NO_RES},
    '{MODE_STORE,  64'd2,    8'hC3, 1'b0, NO_RES},
    '{MODE_MARK,   64'd4,    8'h00, 1'b0, NO_RES},
    '{MODE_PULL,   64'd0,    8'h00, 1'b0, NO_RES},
    '{MODE_STORE,  64'd3,    8'h96, 1'b0, NO_RES},
    '{MODE_PULL,   64'd0,    8'h00, 1'b0, NO_RES},
    '{MODE_STORE,  64'd4,    8'h69, 1'b0, NO_RES},
    '{MODE_PULL,   64'd0,    8'h00, 1'b0, NO_RES},
    '{MODE_PULL,   64'd0,    8'h00, 1'b0, NO_RES}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       mode_i;
  logic [IdxW-1:0]  stream_index_i;
  logic [ByteW-1:0] data_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             byte_valid_o;
  logic [ByteW-1:0] out_byte_o;
  logic             stream_closed_o;
  logic [PendW-1:0] pending_count_o;

  stream_byte_reassembler_unit #(
    .WINDOW_BYTES(WIN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .stream_index_i (stream_index_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_valid_o   (byte_valid_o),
    .out_byte_o     (out_byte_o),
    .stream_closed_o(stream_closed_o),
    .pending_count_o(pending_count_o)
  );

  // predictor state
  logic [ByteW-1:0] slot_data [WIN];
  logic             slot_full [WIN];
  logic [IdxW-1:0]  head_idx;
  logic [IdxW-1:0]  eos_idx;
  logic             eos_seen;
  int unsigned      held_cnt;

  reasm_result_t    expected_q [$];
  int unsigned      mismatch_cnt;
  int unsigned      results_seen;
  int unsigned      idle_cycles = 0;
  logic             calm_tx;

  always #1 clk_i = ~clk_i;

  function automatic reasm_result_t reassemble_step(logic [1:0] md, logic [IdxW-1:0] ix,
                                                    logic [ByteW-1:0] dat);
    reasm_result_t r;
    int unsigned s;
    r = '0;
    case (md)
      MODE_STORE: begin
        if (ix >= head_idx && (ix - head_idx) < WIN) begin
          s = int'(ix % WIN);
          if (!slot_full[s]) begin
            slot_full[s] = 1'b1;
            held_cnt++;
          end
          slot_data[s] = dat;
        end
      end
      MODE_MARK: begin
        eos_seen = 1'b1;
        eos_idx = ix;
      end
      MODE_PULL: begin
        s = int'(head_idx % WIN);
        if (slot_full[s]) begin
          r.got = 1'b1;
          r.val = slot_data[s];
          slot_full[s] = 1'b0;
          held_cnt--;
          head_idx++;
        end
      end
      default: ;
    endcase
    r.closed = eos_seen && (head_idx >= eos_idx);
    r.pend = held_cnt[PendW-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < 40)
      $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_item(logic [1:0] md, logic [IdxW-1:0] ix, logic [ByteW-1:0] dat,
                           logic typed, reasm_result_t want);
    int unsigned gap;
    reasm_result_t pred;
    if ($urandom_range(0, 99) < 2) calm_tx = !calm_tx;
    gap = (calm_tx || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    stream_index_i <= ix;
    data_byte_i <= dat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = reassemble_step(md, ix, dat);
    expected_q.push_back(typed ? want : pred);
  endtask

  initial begin
    int unsigned order [WIN];
    int unsigned j, tmp, n_real, pick, sub;
    logic [1:0] md;
    logic [IdxW-1:0] ix, base;
    logic [ByteW-1:0] dat;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_PULL;
    stream_index_i = '0;
    data_byte_i = '0;
    out_ready_i = 1'b0;
    for (int i = 0; i < WIN; i++) slot_full[i] = 1'b0;
    head_idx = '0;
    eos_idx = '0;
    eos_seen = 1'b0;
    held_cnt = 0;
    mismatch_cnt = 0;
    calm_tx = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].md, DIRECTED_ROWS[i].ix, DIRECTED_ROWS[i].dat,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    // fill the whole window in shuffled order
    for (int i = 0; i < WIN; i++) order[i] = i;
    for (int i = WIN - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    base = head_idx;
    for (int i = 0; i < WIN; i++)
      send_item(MODE_STORE, base + order[i], 8'($urandom_range(0, 255)), 1'b0, NO_RES);

    n_real = 0;
    while (n_real < MIXED_ITEMS) begin
      pick = $urandom_range(0, 99);
      dat = 8'($urandom_range(0, 255));
      ix = {$urandom, $urandom};
      n_real++;
      if (pick < 44) begin
        md = MODE_STORE;
        sub = $urandom_range(0, 9);
        if (sub < 6) ix = head_idx + $urandom_range(0, 15);
        else if (sub < 8) ix = head_idx + $urandom_range(0, WIN - 1);
        else if (sub == 8) ix = head_idx + WIN + $urandom_range(0, 3);
        else ix = head_idx - $urandom_range(1, 4);
      end else if (pick < 84) begin
        md = MODE_PULL;
      end else if (pick < 90) begin
        md = MODE_MARK;
        if ($urandom_range(0, 7) != 0) ix = head_idx + $urandom_range(0, 8) - 2;
      end else if (pick < 95) begin
        md = MODE_UNUSED;
        n_real--;
      end else begin
        md = MODE_STORE;
        n_real--;
      end
      send_item(md, ix, dat, 1'b0, NO_RES);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: checks every transfer and drives ready with random stalls and one long hold
  initial begin
    int unsigned stall;
    logic calm_rx;
    logic hold_done;
    reasm_result_t want;
    stall = 0;
    calm_rx = 1'b0;
    hold_done = 1'b0;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with none expected", 64'(pending_count_o), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (byte_valid_o !== want.got)
            report_mismatch("byte_valid", 64'(byte_valid_o), 64'(want.got));
          if (out_byte_o !== want.val)
            report_mismatch("out_byte", 64'(out_byte_o), 64'(want.val));
          if (stream_closed_o !== want.closed)
            report_mismatch("stream_closed", 64'(stream_closed_o), 64'(want.closed));
          if (pending_count_o !== want.pend)
            report_mismatch("pending_count", 64'(pending_count_o), 64'(want.pend));
        end
        results_seen++;
      end
      if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
      if (stall == 0 && !hold_done && results_seen >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall == 0 && !calm_rx && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
